### rtl/core/qrs_pkg.sv
// Shared constants and types for the quadratic root solver.
// No dependencies; the top level, the checker and the testbench import this package.
package qrs_pkg;

    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        KIND_NOT_QUAD = 2'd0,
        KIND_NO_REAL  = 2'd1,
        KIND_DOUBLE   = 2'd2,
        KIND_TWO      = 2'd3
    } t_root_kind;

endpackage

### rtl/core/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
// Standalone; instantiated in a row by quadratic_root_solver_unit.
module qrs_sqrt_cell #(
    parameter int RB     = 33,
    parameter int SIDE_W = 34
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2*RB-1:0]   i_rad,
    input  logic [RB:0]       i_rem,
    input  logic [RB-1:0]     i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [2*RB-1:0]   o_rad,
    output logic [RB:0]       o_rem,
    output logic [RB-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [2*RB-1:0]   r_rad;
    logic [RB:0]       r_rem;
    logic [RB-1:0]     r_root;
    logic [SIDE_W-1:0] r_side;
    logic [RB:0]       n_rem;
    logic [RB-1:0]     n_root;
    logic [RB+2:0]     w_remc;
    logic [RB+2:0]     w_trial;
    logic [RB+2:0]     w_diff;

    always_comb begin
        w_remc  = {i_rem, i_rad[2*RB-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_diff  = w_remc - w_trial;
        if (w_remc >= w_trial) begin
            n_rem  = w_diff[RB:0];
            n_root = {i_root[RB-2:0], 1'b1};
        end else begin
            n_rem  = w_remc[RB:0];
            n_root = {i_root[RB-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_rad  <= {i_rad[2*RB-3:0], 2'b00};
        r_rem  <= n_rem;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

### rtl/core/qrs_div_cell.sv
// One cell of a restoring divider chain: settles one quotient bit per cell.
// Standalone; instantiated in rows by quadratic_root_solver_unit.
module qrs_div_cell #(
    parameter int NQ     = 34,
    parameter int DW     = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [NQ-1:0]     i_num,
    input  logic [DW-1:0]     i_rem,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NQ-1:0]     o_num,
    output logic [DW-1:0]     o_rem,
    output logic [DW-1:0]     o_den,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid;
    logic [NQ-1:0]     r_num;
    logic [DW-1:0]     r_rem;
    logic [DW-1:0]     r_den;
    logic [SIDE_W-1:0] r_side;
    logic [DW:0]       w_remc;
    logic [DW:0]       w_diff;
    logic              w_q;
    logic [DW-1:0]     n_rem;

    always_comb begin
        w_remc = {i_rem, i_num[NQ-1]};
        w_diff = w_remc - {1'b0, i_den};
        w_q    = (w_remc >= {1'b0, i_den});
        n_rem  = w_q ? w_diff[DW-1:0] : w_remc[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_num  <= {i_num[NQ-2:0], w_q};
        r_rem  <= n_rem;
        r_den  <= i_den;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

### rtl/core/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: products, discriminant, square
// root chain and two divider chains. Depends on qrs_pkg and the two cells.
//
// The unit accepts one coefficient set every clock cycle and never raises
// o_busy. Each item passes through the product register, the discriminant
// register, one register per root bit in the square root chain, the
// numerator register, one register per quotient bit in the divider chains
// and the output register before it comes out on o_done. The result is
// shown for a single cycle only.
module quadratic_root_solver_unit
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic signed [COEF_BITS-1:0]       i_coef_quad,
    input  logic signed [COEF_BITS-1:0]       i_coef_lin,
    input  logic signed [COEF_BITS-1:0]       i_coef_const,
    output logic                              o_done,
    output logic [1:0]                        o_root_kind,
    output logic signed [COEF_BITS+FRAC_BITS+2:0] o_root_low,
    output logic signed [COEF_BITS+FRAC_BITS+2:0] o_root_high
);

    localparam int C    = COEF_BITS;
    localparam int F    = FRAC_BITS;
    localparam int RB   = C + 1 + F;
    localparam int NW   = C + F + 3;
    localparam int NQ   = NW - 1;
    localparam int DW   = C + 1;
    localparam int DWID = 2 * C + 3;
    localparam int SS_W = 2 + 2 * C;
    localparam int LS_W = 3;
    localparam int LAT  = 2 + RB + 1 + NQ + 1;

    // Products.
    logic                    r1_valid;
    logic signed [2*C-1:0]   r1_bb;
    logic signed [2*C-1:0]   r1_ac;
    logic signed [C-1:0]     r1_a;
    logic signed [C-1:0]     r1_b;
    logic signed [2*C-1:0]   w_bb;
    logic signed [2*C-1:0]   w_ac;

    assign w_bb = i_coef_lin * i_coef_lin;
    assign w_ac = i_coef_quad * i_coef_const;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_start;
        end
        r1_bb <= w_bb;
        r1_ac <= w_ac;
        r1_a  <= i_coef_quad;
        r1_b  <= i_coef_lin;
    end

    // Discriminant and classification.
    logic signed [DWID-1:0] w_d;
    t_root_kind             w_kind;

    always_comb begin
        w_d = $signed({{3{r1_bb[2*C-1]}}, r1_bb})
            - ($signed({{3{r1_ac[2*C-1]}}, r1_ac}) <<< 2);
        priority if (r1_a == '0) begin
            w_kind = KIND_NOT_QUAD;
        end else if (w_d[DWID-1]) begin
            w_kind = KIND_NO_REAL;
        end else if (w_d == '0) begin
            w_kind = KIND_DOUBLE;
        end else begin
            w_kind = KIND_TWO;
        end
    end

    logic              s_valid [0:RB];
    logic [2*RB-1:0]   s_rad   [0:RB];
    logic [RB:0]       s_rem   [0:RB];
    logic [RB-1:0]     s_root  [0:RB];
    logic [SS_W-1:0]   s_side  [0:RB];
    logic              r2_valid;
    logic [2*RB-1:0]   r2_rad;
    logic [SS_W-1:0]   r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_rad  <= {w_d[2*C+1:0], {(2*F){1'b0}}};
        r2_side <= {w_kind, r1_a, r1_b};
    end

    assign s_valid[0] = r2_valid;
    assign s_rad[0]   = r2_rad;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = r2_side;

    for (genvar gi = 0; gi < RB; gi++) begin : g_sqrt
        qrs_sqrt_cell #(.RB(RB), .SIDE_W(SS_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[gi]),
            .i_rad   (s_rad[gi]),
            .i_rem   (s_rem[gi]),
            .i_root  (s_root[gi]),
            .i_side  (s_side[gi]),
            .o_valid (s_valid[gi+1]),
            .o_rad   (s_rad[gi+1]),
            .o_rem   (s_rem[gi+1]),
            .o_root  (s_root[gi+1]),
            .o_side  (s_side[gi+1])
        );
    end

    // Numerators, their magnitudes and the divisor.
    logic [1:0]            w_s_kind;
    logic signed [C-1:0]   w_s_a;
    logic signed [C-1:0]   w_s_b;
    logic signed [NW-1:0]  w_nb;
    logic signed [NW-1:0]  w_r;
    logic signed [NW-1:0]  w_num_lo;
    logic signed [NW-1:0]  w_num_hi;
    logic [NW-1:0]         w_mag_lo;
    logic [NW-1:0]         w_mag_hi;
    logic [C:0]            w_aabs;

    always_comb begin
        {w_s_kind, w_s_a, w_s_b} = s_side[RB];
        w_nb     = -($signed({{(NW-C){w_s_b[C-1]}}, w_s_b}) <<< F);
        w_r      = $signed({2'b00, s_root[RB]});
        w_num_lo = w_nb - w_r;
        w_num_hi = w_nb + w_r;
        w_mag_lo = w_num_lo[NW-1] ? -w_num_lo : w_num_lo;
        w_mag_hi = w_num_hi[NW-1] ? -w_num_hi : w_num_hi;
        w_aabs   = w_s_a[C-1] ? -{w_s_a[C-1], w_s_a} : {w_s_a[C-1], w_s_a};
    end

    logic              r3_valid;
    logic [NQ-1:0]     r3_mag_lo;
    logic [NQ-1:0]     r3_mag_hi;
    logic [DW-1:0]     r3_den;
    logic [LS_W-1:0]   r3_side_lo;
    logic              r3_neg_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= s_valid[RB];
        end
        r3_mag_lo  <= w_mag_lo[NQ-1:0];
        r3_mag_hi  <= w_mag_hi[NQ-1:0];
        r3_den     <= {w_aabs[C-1:0], 1'b0};
        r3_side_lo <= {w_s_kind, w_num_lo[NW-1] ^ w_s_a[C-1]};
        r3_neg_hi  <= w_num_hi[NW-1] ^ w_s_a[C-1];
    end

    logic            dl_valid [0:NQ];
    logic [NQ-1:0]   dl_num   [0:NQ];
    logic [DW-1:0]   dl_rem   [0:NQ];
    logic [DW-1:0]   dl_den   [0:NQ];
    logic [LS_W-1:0] dl_side  [0:NQ];
    logic            dh_valid [0:NQ];
    logic [NQ-1:0]   dh_num   [0:NQ];
    logic [DW-1:0]   dh_rem   [0:NQ];
    logic [DW-1:0]   dh_den   [0:NQ];
    logic [0:0]      dh_side  [0:NQ];

    assign dl_valid[0] = r3_valid;
    assign dl_num[0]   = r3_mag_lo;
    assign dl_rem[0]   = '0;
    assign dl_den[0]   = r3_den;
    assign dl_side[0]  = r3_side_lo;
    assign dh_valid[0] = r3_valid;
    assign dh_num[0]   = r3_mag_hi;
    assign dh_rem[0]   = '0;
    assign dh_den[0]   = r3_den;
    assign dh_side[0]  = r3_neg_hi;

    for (genvar gj = 0; gj < NQ; gj++) begin : g_div
        qrs_div_cell #(.NQ(NQ), .DW(DW), .SIDE_W(LS_W)) u_lo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dl_valid[gj]),
            .i_num   (dl_num[gj]),
            .i_rem   (dl_rem[gj]),
            .i_den   (dl_den[gj]),
            .i_side  (dl_side[gj]),
            .o_valid (dl_valid[gj+1]),
            .o_num   (dl_num[gj+1]),
            .o_rem   (dl_rem[gj+1]),
            .o_den   (dl_den[gj+1]),
            .o_side  (dl_side[gj+1])
        );
        qrs_div_cell #(.NQ(NQ), .DW(DW), .SIDE_W(1)) u_hi (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dh_valid[gj]),
            .i_num   (dh_num[gj]),
            .i_rem   (dh_rem[gj]),
            .i_den   (dh_den[gj]),
            .i_side  (dh_side[gj]),
            .o_valid (dh_valid[gj+1]),
            .o_num   (dh_num[gj+1]),
            .o_rem   (dh_rem[gj+1]),
            .o_den   (dh_den[gj+1]),
            .o_side  (dh_side[gj+1])
        );
    end

    // Sign and output register.
    logic                 w_has_roots;
    logic signed [NW-1:0] n_root_low;
    logic signed [NW-1:0] n_root_high;
    logic                 r_done;
    logic [1:0]           r_kind;
    logic signed [NW-1:0] r_root_low;
    logic signed [NW-1:0] r_root_high;

    always_comb begin
        w_has_roots = dl_side[NQ][2];
        n_root_low  = dl_side[NQ][0] ? -$signed({1'b0, dl_num[NQ]})
                                     : $signed({1'b0, dl_num[NQ]});
        n_root_high = dh_side[NQ][0] ? -$signed({1'b0, dh_num[NQ]})
                                     : $signed({1'b0, dh_num[NQ]});
        if (!w_has_roots) begin
            n_root_low  = '0;
            n_root_high = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= dl_valid[NQ];
        end
        r_kind      <= dl_side[NQ][2:1];
        r_root_low  <= n_root_low;
        r_root_high <= n_root_high;
    end

    assign o_busy      = 1'b0;
    assign o_done      = r_done;
    assign o_root_kind = r_kind;
    assign o_root_low  = r_root_low;
    assign o_root_high = r_root_high;

    a_no_roots_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_root_kind[1] |-> o_root_low == '0 && o_root_high == '0)
        else $error("Roots are not zero for an item without real roots.");

    a_double_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_root_kind == KIND_DOUBLE |-> o_root_low == o_root_high)
        else $error("Double root item has differing roots.");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dl_valid[NQ] == dh_valid[NQ])
        else $error("Divider lanes are out of step.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, LAT))
        else $error("Result item without a matching start.");

endmodule

### tb/sv/quadratic_root_solver_unit_checker.sv
// Checker for the quadratic root solver: watches accepted items and results,
// computes the expected roots and compares them. Depends on qrs_pkg.
module quadratic_root_solver_unit_checker
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic                                  i_busy,
    input  logic signed [COEF_BITS-1:0]           i_coef_quad,
    input  logic signed [COEF_BITS-1:0]           i_coef_lin,
    input  logic signed [COEF_BITS-1:0]           i_coef_const,
    input  logic                                  i_done,
    input  logic [1:0]                            i_root_kind,
    input  logic signed [COEF_BITS+FRAC_BITS+2:0] i_root_low,
    input  logic signed [COEF_BITS+FRAC_BITS+2:0] i_root_high,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROOT_BITS = COEF_BITS + FRAC_BITS + 3;

    typedef struct {
        t_root_kind                  kind;
        logic signed [ROOT_BITS-1:0] low;
        logic signed [ROOT_BITS-1:0] high;
    } t_roots;

    t_roots expected_roots[$];

    function automatic logic [127:0] scaled_sqrt(input logic [127:0] v);
        logic [127:0] rem;
        logic [127:0] root;
        logic [127:0] trial;
        rem = 0;
        root = 0;
        for (int p = 126; p >= 0; p -= 2) begin
            rem = (rem << 2) | ((v >> p) & 128'd3);
            trial = (root << 2) | 128'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 128'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic t_roots solve_roots(input longint a, input longint b, input longint c);
        t_roots res;
        longint d;
        longint nb;
        longint den;
        longint r;
        res.kind = KIND_NOT_QUAD;
        res.low = '0;
        res.high = '0;
        if (a != 0) begin
            d = b * b - 4 * a * c;
            if (d < 0) begin
                res.kind = KIND_NO_REAL;
            end else begin
                nb = -(b <<< FRAC_BITS);
                den = 2 * a;
                if (d == 0) begin
                    res.kind = KIND_DOUBLE;
                    res.low = ROOT_BITS'(nb / den);
                    res.high = res.low;
                end else begin
                    r = longint'(scaled_sqrt(128'(d) << (2 * FRAC_BITS)));
                    res.kind = KIND_TWO;
                    res.low = ROOT_BITS'((nb - r) / den);
                    res.high = ROOT_BITS'((nb + r) / den);
                end
            end
        end
        return res;
    endfunction

    assign o_pending = expected_roots.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n && i_done) begin
            if (expected_roots.size() == 0) begin
                $error("result with no item outstanding");
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = expected_roots.pop_front();
                if (i_root_kind !== want.kind || i_root_low !== want.low ||
                    i_root_high !== want.high) begin
                    if (i_root_kind !== want.kind)
                        $error("root_kind expected %0d actual %0d", want.kind, i_root_kind);
                    if (i_root_low !== want.low)
                        $error("root_low expected %0d actual %0d", want.low, i_root_low);
                    if (i_root_high !== want.high)
                        $error("root_high expected %0d actual %0d", want.high, i_root_high);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
        if (i_rst_n && i_start && !i_busy)
            expected_roots.push_back(solve_roots(i_coef_quad, i_coef_lin, i_coef_const));
    end
endmodule

### tb/sv/quadratic_root_solver_unit_tb.sv
// Testbench top for the quadratic root solver: clock, reset, directed and
// random coefficient items, verdict. Depends on qrs_pkg, the unit and the checker.
module quadratic_root_solver_unit_tb;
    import qrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEF_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int LATENCY = 2 * COEF_BITS + 2 * FRAC_BITS + 7;
    localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
    localparam int RANDOM_ITEMS = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic signed [COEF_BITS-1:0] i_coef_quad = '0;
    logic signed [COEF_BITS-1:0] i_coef_lin = '0;
    logic signed [COEF_BITS-1:0] i_coef_const = '0;
    logic o_busy;
    logic o_done;
    logic [1:0] o_root_kind;
    logic signed [COEF_BITS+FRAC_BITS+2:0] o_root_low;
    logic signed [COEF_BITS+FRAC_BITS+2:0] o_root_high;
    int fail_count;
    int pending;
    int idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    quadratic_root_solver_unit #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_coef_quad, .i_coef_lin,
        .i_coef_const, .o_done, .o_root_kind, .o_root_low, .o_root_high
    );

    quadratic_root_solver_unit_checker #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) checker_i (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_coef_quad, .i_coef_lin,
        .i_coef_const, .i_done(o_done), .i_root_kind(o_root_kind),
        .i_root_low(o_root_low), .i_root_high(o_root_high),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_coefs(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                              input bit gaps);
        while (gaps && $urandom_range(99) < 7) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_coef_quad <= a;
        i_coef_lin <= b;
        i_coef_const <= c;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(16)) - 8);
            3: return 16'($signed($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] a, b, c, k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_coefs(16'sd0, 16'sd5, 16'sd3, 0);
        send_coefs(16'sd1, 16'sd0, 16'sd1, 0);
        send_coefs(16'sd1, -16'sd2, 16'sd1, 0);
        send_coefs(16'sd1, 16'sd0, -16'sd1, 0);
        send_coefs(16'sh8000, 16'sh8000, 16'sh7fff, 0);
        send_coefs(16'sh7fff, 16'sh8000, 16'sh8000, 0);
        send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_coefs(16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_coefs(16'sd1, 16'sh8000, 16'sh8000, 0);
        send_coefs(16'sd1, 16'sh8000, 16'sd0, 0);
        send_coefs(-16'sd1, 16'sh7fff, 16'sh7fff, 0);
        send_coefs(16'sh8000, 16'sd0, 16'sd0, 0);
        send_coefs(16'sd3, 16'sd7, -16'sd2, 0);
        send_coefs(-16'sd3, 16'sd7, 16'sd2, 0);
        send_coefs(16'sd4, 16'sd4, 16'sd1, 0);
        send_coefs(16'sd0, 16'sd0, 16'sd0, 0);
        send_coefs(16'hffff, 16'hffff, 16'hffff, 0);
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            a = pick_coef();
            b = pick_coef();
            c = pick_coef();
            if ($urandom_range(9) == 0) begin
                k = 16'($signed($urandom_range(200)) - 100);
                a = 16'sd1;
                b = 16'(-2 * $signed(k));
                c = 16'($signed(k) * $signed(k));
            end
            send_coefs(a, b, c, !(n >= 300 && n < 500));
            if (n == 600) begin
                i_start <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
        end
        i_start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
